@@ sv/tsb_pkg.sv @@
// Shared constants, codes and pipeline types of the texture sampler.
package tsb_pkg;

  localparam int MAX_DIM         = 128;
  localparam int COORD_FRAC_BITS = 16;
  localparam int WEIGHT_BITS     = 8;

  localparam int XY_W      = 7;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int TEXEL_W   = NUM_CH * CH_W;
  localparam int COORD_W   = 17;
  localparam int DIM_W     = 8;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int PROD_W    = COORD_W + DIM_W;
  localparam int TB_W      = PROD_W + 1;
  localparam int FL_W      = TB_W - COORD_FRAC_BITS;
  localparam int NI_W      = PROD_W - COORD_FRAC_BITS;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = TEXEL_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = CFG_IDX_W'(2);

  localparam logic ACT_LOAD       = 1'b0;
  localparam logic ACT_SAMPLE     = 1'b1;
  localparam logic FILTER_BILINEAR = 1'b0;
  localparam logic FILTER_NEAREST  = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic                action;
    logic [XY_W-1:0]     texel_x;
    logic [XY_W-1:0]     texel_y;
    logic [CH_W-1:0]     red_in;
    logic [CH_W-1:0]     green_in;
    logic [CH_W-1:0]     blue_in;
    logic [COORD_W-1:0]  u_coord;
    logic [COORD_W-1:0]  v_coord;
  } tsb_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             nearest;
  } tsb_cfg_t;

  typedef struct packed {
    logic                   valid;
    logic                   load;
    logic [IDX_W-1:0]       x0;
    logic [IDX_W-1:0]       x1;
    logic [IDX_W-1:0]       y0;
    logic [IDX_W-1:0]       y1;
    logic [WEIGHT_BITS-1:0] wx;
    logic [WEIGHT_BITS-1:0] wy;
    logic [TEXEL_W-1:0]     texel;
  } tsb_addr_t;

  typedef struct packed {
    logic                   valid;
    logic [WEIGHT_BITS-1:0] wx;
    logic [WEIGHT_BITS-1:0] wy;
    logic [TEXEL_W-1:0]     tl;
    logic [TEXEL_W-1:0]     tr;
    logic [TEXEL_W-1:0]     bl;
    logic [TEXEL_W-1:0]     br;
  } tsb_quad_t;

endpackage

@@ sv/tsb_coord.sv @@
// Coordinate stages: scale by the texture size, then floor, weight, wrap and clamp.
module tsb_coord (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                a_valid,
  input  tsb_pkg::tsb_item_t  a_item,
  input  tsb_pkg::tsb_cfg_t   cfg,
  output tsb_pkg::tsb_addr_t  addr_o
);

  localparam logic [tsb_pkg::TB_W-1:0] BIAS =
    tsb_pkg::TB_W'(2 ** (tsb_pkg::COORD_FRAC_BITS - 1));
  localparam logic [tsb_pkg::FL_W:0] ONE_FL = (tsb_pkg::FL_W + 1)'(1);

  function automatic logic [tsb_pkg::DIM_W-1:0] eff_dim(input logic [tsb_pkg::DIM_W-1:0] d);
    logic [tsb_pkg::DIM_W-1:0] r;
    r = d;
    if (d == '0) r = tsb_pkg::DIM_W'(1);
    else if (d > tsb_pkg::DIM_W'(tsb_pkg::MAX_DIM)) r = tsb_pkg::DIM_W'(tsb_pkg::MAX_DIM);
    return r;
  endfunction

  function automatic logic [tsb_pkg::IDX_W-1:0] wrap_index(
    input logic [tsb_pkg::FL_W:0]    b,
    input logic [tsb_pkg::DIM_W-1:0] dim
  );
    logic [tsb_pkg::FL_W:0] i;
    logic [tsb_pkg::FL_W:0] d;
    d = (tsb_pkg::FL_W + 1)'(dim);
    if (b == '0) begin
      i = d - ONE_FL;
    end else begin
      i = b - ONE_FL;
      if (i >= d) i = i - d;
      if (i >= d) i = d - ONE_FL;
    end
    return i[tsb_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [tsb_pkg::IDX_W-1:0] near_index(
    input logic [tsb_pkg::NI_W-1:0]  n,
    input logic [tsb_pkg::DIM_W-1:0] dim
  );
    logic [tsb_pkg::NI_W-1:0] d1;
    logic [tsb_pkg::NI_W-1:0] r;
    d1 = tsb_pkg::NI_W'(dim) - tsb_pkg::NI_W'(1);
    r  = (n > d1) ? d1 : n;
    return r[tsb_pkg::IDX_W-1:0];
  endfunction

  logic                        b_valid_r;
  tsb_pkg::tsb_item_t          b_item_r;
  logic [tsb_pkg::PROD_W-1:0]  b_pu_r;
  logic [tsb_pkg::PROD_W-1:0]  b_pv_r;
  logic [tsb_pkg::PROD_W-1:0]  b_pu_nxt;
  logic [tsb_pkg::PROD_W-1:0]  b_pv_nxt;
  logic [tsb_pkg::DIM_W-1:0]   w_eff;
  logic [tsb_pkg::DIM_W-1:0]   h_eff;

  logic [tsb_pkg::TB_W-1:0]    tbx;
  logic [tsb_pkg::TB_W-1:0]    tby;
  logic [tsb_pkg::FL_W:0]      fbx;
  logic [tsb_pkg::FL_W:0]      fby;
  tsb_pkg::tsb_addr_t          c_r;
  tsb_pkg::tsb_addr_t          c_nxt;

  assign w_eff    = eff_dim(cfg.width);
  assign h_eff    = eff_dim(cfg.height);
  assign b_pu_nxt = tsb_pkg::PROD_W'(a_item.u_coord) * tsb_pkg::PROD_W'(w_eff);
  assign b_pv_nxt = tsb_pkg::PROD_W'(a_item.v_coord) * tsb_pkg::PROD_W'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid;
    end
    if (en) begin
      b_item_r <= a_item;
      b_pu_r   <= b_pu_nxt;
      b_pv_r   <= b_pv_nxt;
    end
  end

  assign tbx = tsb_pkg::TB_W'(b_pu_r) + BIAS;
  assign tby = tsb_pkg::TB_W'(b_pv_r) + BIAS;
  assign fbx = {1'b0, tbx[tsb_pkg::TB_W-1 -: tsb_pkg::FL_W]};
  assign fby = {1'b0, tby[tsb_pkg::TB_W-1 -: tsb_pkg::FL_W]};

  always_comb begin
    c_nxt       = '0;
    c_nxt.valid = b_valid_r;
    c_nxt.load  = (b_item_r.action == tsb_pkg::ACT_LOAD);
    c_nxt.texel = {b_item_r.red_in, b_item_r.green_in, b_item_r.blue_in};
    if (b_item_r.action == tsb_pkg::ACT_LOAD) begin
      c_nxt.valid = b_valid_r &&
                    (int'(b_item_r.texel_x) < tsb_pkg::MAX_DIM) &&
                    (int'(b_item_r.texel_y) < tsb_pkg::MAX_DIM);
      c_nxt.x0 = tsb_pkg::IDX_W'(b_item_r.texel_x);
      c_nxt.y0 = tsb_pkg::IDX_W'(b_item_r.texel_y);
      c_nxt.x1 = c_nxt.x0;
      c_nxt.y1 = c_nxt.y0;
    end else if (cfg.nearest) begin
      c_nxt.x0 = near_index(b_pu_r[tsb_pkg::PROD_W-1 -: tsb_pkg::NI_W], w_eff);
      c_nxt.y0 = near_index(b_pv_r[tsb_pkg::PROD_W-1 -: tsb_pkg::NI_W], h_eff);
      c_nxt.x1 = c_nxt.x0;
      c_nxt.y1 = c_nxt.y0;
    end else begin
      c_nxt.x0 = wrap_index(fbx, w_eff);
      c_nxt.x1 = wrap_index(fbx + ONE_FL, w_eff);
      c_nxt.y0 = wrap_index(fby, h_eff);
      c_nxt.y1 = wrap_index(fby + ONE_FL, h_eff);
      c_nxt.wx = tbx[tsb_pkg::COORD_FRAC_BITS-1 -: tsb_pkg::WEIGHT_BITS];
      c_nxt.wy = tby[tsb_pkg::COORD_FRAC_BITS-1 -: tsb_pkg::WEIGHT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r.valid <= c_nxt.valid;
    end
    if (en) begin
      c_r.load  <= c_nxt.load;
      c_r.x0    <= c_nxt.x0;
      c_r.x1    <= c_nxt.x1;
      c_r.y0    <= c_nxt.y0;
      c_r.y1    <= c_nxt.y1;
      c_r.wx    <= c_nxt.wx;
      c_r.wy    <= c_nxt.wy;
      c_r.texel <= c_nxt.texel;
    end
  end

  assign addr_o = c_r;

endmodule

@@ sv/tsb_texel_mem.sv @@
// Texel store: two copies of the texture, each read at two addresses per cycle.
module tsb_texel_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tsb_pkg::tsb_addr_t  addr_i,
  output tsb_pkg::tsb_quad_t  quad_o
);

  logic [tsb_pkg::TEXEL_W-1:0] top_mem [tsb_pkg::DEPTH];
  logic [tsb_pkg::TEXEL_W-1:0] bot_mem [tsb_pkg::DEPTH];

  logic [tsb_pkg::ADDR_W-1:0] a00;
  logic [tsb_pkg::ADDR_W-1:0] a10;
  logic [tsb_pkg::ADDR_W-1:0] a01;
  logic [tsb_pkg::ADDR_W-1:0] a11;
  logic                       wr_en;
  tsb_pkg::tsb_quad_t         q_r;

  assign a00   = {addr_i.y0, addr_i.x0};
  assign a10   = {addr_i.y0, addr_i.x1};
  assign a01   = {addr_i.y1, addr_i.x0};
  assign a11   = {addr_i.y1, addr_i.x1};
  assign wr_en = en && addr_i.valid && addr_i.load;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[a00] <= addr_i.texel;
      bot_mem[a00] <= addr_i.texel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= addr_i.valid && !addr_i.load;
    end
    if (en) begin
      q_r.tl <= top_mem[a00];
      q_r.tr <= top_mem[a10];
      q_r.bl <= bot_mem[a01];
      q_r.br <= bot_mem[a11];
      q_r.wx <= addr_i.wx;
      q_r.wy <= addr_i.wy;
    end
  end

  assign quad_o = q_r;

endmodule

@@ sv/tsb_filter.sv @@
// Filter stages: vertical lerp of both columns, then horizontal lerp.
module tsb_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tsb_pkg::tsb_quad_t            quad_i,
  output logic                          f_valid,
  output logic [tsb_pkg::TEXEL_W-1:0]   f_data
);

  localparam int MUL_W = tsb_pkg::CH_W + tsb_pkg::WEIGHT_BITS + 1;
  localparam logic [tsb_pkg::WEIGHT_BITS:0] W_ONE =
    (tsb_pkg::WEIGHT_BITS + 1)'(2 ** tsb_pkg::WEIGHT_BITS);

  function automatic logic [tsb_pkg::CH_W-1:0] lerp(
    input logic [tsb_pkg::CH_W-1:0]        a,
    input logic [tsb_pkg::CH_W-1:0]        b,
    input logic [tsb_pkg::WEIGHT_BITS-1:0] w
  );
    logic [MUL_W:0] s;
    s = (MUL_W + 1)'(MUL_W'(a) * MUL_W'(W_ONE - {1'b0, w})) +
        (MUL_W + 1)'(MUL_W'(b) * MUL_W'(w));
    return s[tsb_pkg::WEIGHT_BITS +: tsb_pkg::CH_W];
  endfunction

  function automatic logic [tsb_pkg::CH_W-1:0] chan(
    input logic [tsb_pkg::TEXEL_W-1:0] t,
    input int                           c
  );
    return t[tsb_pkg::TEXEL_W - 1 - c * tsb_pkg::CH_W -: tsb_pkg::CH_W];
  endfunction

  logic                           e_valid_r;
  logic [tsb_pkg::WEIGHT_BITS-1:0] e_wx_r;
  logic [tsb_pkg::CH_W-1:0]       e_left_r  [tsb_pkg::NUM_CH];
  logic [tsb_pkg::CH_W-1:0]       e_right_r [tsb_pkg::NUM_CH];
  logic [tsb_pkg::CH_W-1:0]       e_left_nxt  [tsb_pkg::NUM_CH];
  logic [tsb_pkg::CH_W-1:0]       e_right_nxt [tsb_pkg::NUM_CH];
  logic                           f_valid_r;
  logic [tsb_pkg::TEXEL_W-1:0]    f_data_r;
  logic [tsb_pkg::TEXEL_W-1:0]    f_data_nxt;

  always_comb begin
    for (int c = 0; c < tsb_pkg::NUM_CH; c++) begin
      e_left_nxt[c]  = lerp(chan(quad_i.tl, c), chan(quad_i.bl, c), quad_i.wy);
      e_right_nxt[c] = lerp(chan(quad_i.tr, c), chan(quad_i.br, c), quad_i.wy);
    end
  end

  always_comb begin
    for (int c = 0; c < tsb_pkg::NUM_CH; c++) begin
      f_data_nxt[c * tsb_pkg::CH_W +: tsb_pkg::CH_W] = lerp(e_left_r[c], e_right_r[c], e_wx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= quad_i.valid;
      f_valid_r <= e_valid_r;
    end
    if (en) begin
      e_wx_r    <= quad_i.wx;
      e_left_r  <= e_left_nxt;
      e_right_r <= e_right_nxt;
      f_data_r  <= f_data_nxt;
    end
  end

  assign f_valid = f_valid_r;
  assign f_data  = f_data_r;

endmodule

@@ sv/tsb_skid.sv @@
// Output register with a skid entry that decouples the pipeline from the result channel.
module tsb_skid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [tsb_pkg::OUT_DATA_W-1:0]  in_data,
  output logic                            in_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tsb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                            out_valid_r;
  logic [tsb_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                            skid_valid_r;
  logic [tsb_pkg::OUT_DATA_W-1:0]  skid_data_r;
  logic                            up_xfer;

  assign in_ready = !skid_valid_r;
  assign up_xfer  = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= up_xfer;
        out_data_r  <= in_data;
      end
    end else if (up_xfer) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= in_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/texture_sampler_bilinear_nearest.sv @@
// Top level of the texture sampler: ports, configuration registers and input stage.
// The sampler takes one item per cycle unless stalled. A sample returns its color through
// the input register, scale multiply, floor and wrap, texel read, vertical lerp and
// horizontal lerp stages when the result channel is ready; a load writes its texel in
// the read stage and returns nothing. The texture is held twice, each copy read at two
// addresses per cycle, so all four neighbors are fetched in the same cycle. The pipeline
// stalls as a whole only when both the output register and its skid entry are full. The
// texel store has no reset or clearing pass: a texel must be loaded before it is sampled.
module texture_sampler_bilinear_nearest (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // texel_x[6:0], texel_y[13:7], red_in[21:14], green_in[29:22], blue_in[37:30],
  // u_coord[54:38], v_coord[71:55]
  input  logic [tsb_pkg::IN_DATA_W-1:0]   in_tdata,
  // action[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [tsb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int Y_LSB = tsb_pkg::XY_W;
  localparam int R_LSB = 2 * tsb_pkg::XY_W;
  localparam int G_LSB = R_LSB + tsb_pkg::CH_W;
  localparam int B_LSB = G_LSB + tsb_pkg::CH_W;
  localparam int U_LSB = B_LSB + tsb_pkg::CH_W;
  localparam int V_LSB = U_LSB + tsb_pkg::COORD_W;

  logic [tsb_pkg::DIM_W-1:0] tex_width_r;
  logic [tsb_pkg::DIM_W-1:0] tex_height_r;
  logic                      filter_mode_r;
  tsb_pkg::tsb_cfg_t         cfg;

  tsb_pkg::tsb_item_t        in_item;
  logic                      a_valid_r;
  tsb_pkg::tsb_item_t        a_item_r;
  logic                      en;

  tsb_pkg::tsb_addr_t        addr;
  tsb_pkg::tsb_quad_t        quad;
  logic                      f_valid;
  logic [tsb_pkg::TEXEL_W-1:0] f_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r   <= tsb_pkg::DIM_RESET;
      tex_height_r  <= tsb_pkg::DIM_RESET;
      filter_mode_r <= tsb_pkg::FILTER_BILINEAR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsb_pkg::REG_TEX_WIDTH:   tex_width_r   <= tsb_pkg::DIM_W'(cfg_data);
        tsb_pkg::REG_TEX_HEIGHT:  tex_height_r  <= tsb_pkg::DIM_W'(cfg_data);
        tsb_pkg::REG_FILTER_MODE: filter_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.width   = tex_width_r;
  assign cfg.height  = tex_height_r;
  assign cfg.nearest = (filter_mode_r == tsb_pkg::FILTER_NEAREST);

  assign in_item.action   = in_tuser;
  assign in_item.texel_x  = in_tdata[0 +: tsb_pkg::XY_W];
  assign in_item.texel_y  = in_tdata[Y_LSB +: tsb_pkg::XY_W];
  assign in_item.red_in   = in_tdata[R_LSB +: tsb_pkg::CH_W];
  assign in_item.green_in = in_tdata[G_LSB +: tsb_pkg::CH_W];
  assign in_item.blue_in  = in_tdata[B_LSB +: tsb_pkg::CH_W];
  assign in_item.u_coord  = in_tdata[U_LSB +: tsb_pkg::COORD_W];
  assign in_item.v_coord  = in_tdata[V_LSB +: tsb_pkg::COORD_W];

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_tvalid;
    end
    if (en) begin
      a_item_r <= in_item;
    end
  end

  tsb_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .a_valid (a_valid_r),
    .a_item  (a_item_r),
    .cfg     (cfg),
    .addr_o  (addr)
  );

  tsb_texel_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .addr_i (addr),
    .quad_o (quad)
  );

  tsb_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .quad_i  (quad),
    .f_valid (f_valid),
    .f_data  (f_data)
  );

  tsb_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (f_valid),
    .in_data    (f_data),
    .in_ready   (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/tsb_checker.sv @@
// Port-level checker of the texture sampler and its bind to the top level.
module tsb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result was withdrawn before its transfer.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("Stalled result changed before its transfer.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("Input stalled without a stalled result.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("Pipeline not empty after reset.");

endmodule

bind texture_sampler_bilinear_nearest tsb_checker u_tsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
